FILE: sv/plob_pkg.sv
// ---------------------------------------------------------------------------
// plob_pkg
// Shared types, codes and defaults of the price-level order book.
// ---------------------------------------------------------------------------
package plob_pkg;

  localparam int unsigned DEF_LEVELS     = 32;
  localparam int unsigned DEF_PRICE_BITS = 32;
  localparam int unsigned DEF_SIZE_BITS  = 32;
  localparam int unsigned MAX_RESULTS    = 32;

  typedef enum logic [1:0] {
    REQ_DELTA = 2'd0,
    REQ_QUERY = 2'd1,
    REQ_SNAP  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FOREIGN = 2'd1,
    ST_FULL    = 2'd2,
    ST_RSVD    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CMP,
    OP_INS,
    OP_UPD,
    OP_REM
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
  } cell_ctrl_t;

  localparam logic [2:0] ADDR_INSTRUMENT = 3'd0;

endpackage

FILE: sv/plob_cell.sv
// ---------------------------------------------------------------------------
// plob_cell
// One price level of a sorted side; shifts toward or away from its neighbors.
// ---------------------------------------------------------------------------
module plob_cell #(
  parameter int unsigned PRICE_BITS = plob_pkg::DEF_PRICE_BITS,
  parameter int unsigned SIZE_BITS  = plob_pkg::DEF_SIZE_BITS,
  parameter bit          IS_BID     = 1'b1
) (
  input  logic                   clk_i,
  input  plob_pkg::cell_ctrl_t   ctrl_i,
  input  logic                   occ_i,
  input  logic [PRICE_BITS-1:0]  price_i,
  input  logic [SIZE_BITS-1:0]   size_i,
  input  logic                   left_before_i,
  input  logic [PRICE_BITS-1:0]  left_price_i,
  input  logic [SIZE_BITS-1:0]   left_size_i,
  input  logic [PRICE_BITS-1:0]  right_price_i,
  input  logic [SIZE_BITS-1:0]   right_size_i,
  output logic [PRICE_BITS-1:0]  price_o,
  output logic [SIZE_BITS-1:0]   size_o,
  output logic                   before_o,
  output logic                   eq_o
);
  import plob_pkg::*;

  logic [PRICE_BITS-1:0] price_q, price_d;
  logic [SIZE_BITS-1:0]  size_q, size_d;
  logic                  before_q, before_d;
  logic                  eq_q, eq_d;

  always_comb begin
    price_d  = price_q;
    size_d   = size_q;
    before_d = before_q;
    eq_d     = eq_q;
    case (ctrl_i.op)
      OP_CMP: begin
        before_d = occ_i && (IS_BID ? (price_q > price_i) : (price_q < price_i));
        eq_d     = occ_i && (price_q == price_i);
      end
      OP_INS: begin
        if (!before_q) begin
          // insertion point takes the new level, cells past it shift right
          if (left_before_i) begin
            price_d = price_i;
            size_d  = size_i;
          end else begin
            price_d = left_price_i;
            size_d  = left_size_i;
          end
        end
      end
      OP_UPD: begin
        if (eq_q) size_d = size_i;
      end
      OP_REM: begin
        if (!before_q) begin
          price_d = right_price_i;
          size_d  = right_size_i;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    price_q  <= price_d;
    size_q   <= size_d;
    before_q <= before_d;
    eq_q     <= eq_d;
  end

  assign price_o  = price_q;
  assign size_o   = size_q;
  assign before_o = before_q;
  assign eq_o     = eq_q;

endmodule

FILE: sv/price_level_order_book_core.sv
// ---------------------------------------------------------------------------
// price_level_order_book_core
// Order book for one instrument: two rows of level cells, bids and asks.
// ---------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  in      | input     | in_valid_i / in_stall_o     | request fields
//  out     | output    | out_valid_o / out_stall_i   | result fields
//  cfg     | input     | psel/penable/pwrite/pready  | book_instrument
//
// the first result is valid once these steps are done in order: compare in all
// cells, shift or update the row, load the output register
// a snapshot then loads the output register with one result a cycle unless
// stalled, up to 32; the next transaction is taken the cycle after the last
// result is loaded
// reset empties both sides; level contents are never cleared
// a stalled output holds the result and the sequencer waits
// ---------------------------------------------------------------------------
module price_level_order_book_core #(
  parameter int unsigned LEVELS     = plob_pkg::DEF_LEVELS,
  parameter int unsigned PRICE_BITS = plob_pkg::DEF_PRICE_BITS,
  parameter int unsigned SIZE_BITS  = plob_pkg::DEF_SIZE_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] instrument_i,
  input  logic        is_bid_i,
  input  logic [1:0]  action_i,
  input  logic [31:0] price_i,
  input  logic [31:0] size_i,
  input  logic [5:0]  depth_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] best_bid_o,
  output logic [31:0] best_ask_o,
  output logic        bid_present_o,
  output logic        ask_present_o,
  output logic [32:0] spread_o,
  output logic [32:0] mid_twice_o,
  output logic [31:0] level_price_o,
  output logic [31:0] level_size_o,
  output logic        level_valid_o,
  output logic        last_o,
  output logic        book_empty_o
);
  import plob_pkg::*;

  localparam int unsigned CW = $clog2(LEVELS + 1);
  localparam int unsigned KW = $clog2(LEVELS);

  typedef enum logic [1:0] {S_IDLE, S_CMP, S_APPLY, S_EMIT} state_e;

  state_e state_q;
  logic [15:0] inst_q;
  logic [CW-1:0] bid_cnt_q, ask_cnt_q, nres_q;
  logic [KW-1:0] k_q;
  req_e req_q;
  logic [15:0] instr_q;
  logic is_bid_q;
  action_e act_q;
  logic [PRICE_BITS-1:0] price_q;
  logic [SIZE_BITS-1:0] size_q;
  logic [5:0] depth_q;
  status_e stat_q;

  logic out_valid_q;
  status_e o_status_q;
  logic [31:0] o_lp_q, o_ls_q;
  logic o_lv_q, o_last_q;
  logic [31:0] o_bb_q, o_ba_q;
  logic o_bp_q, o_ap_q, o_empty_q;
  logic [32:0] o_sp_q, o_mid_q;

  cell_ctrl_t bid_ctrl, ask_ctrl;
  logic [PRICE_BITS-1:0] bid_p [LEVELS];
  logic [SIZE_BITS-1:0]  bid_s [LEVELS];
  logic [PRICE_BITS-1:0] ask_p [LEVELS];
  logic [SIZE_BITS-1:0]  ask_s [LEVELS];
  logic [LEVELS-1:0] bid_before, bid_eq, ask_before, ask_eq;

  logic [PRICE_BITS-1:0] in_price;
  logic [SIZE_BITS-1:0]  in_size;
  assign in_price = PRICE_BITS'(64'(price_i));
  assign in_size  = SIZE_BITS'(64'(size_i));

  // cell rows
  for (genvar i = 0; i < LEVELS; i++) begin : g_cells
    plob_cell #(.PRICE_BITS(PRICE_BITS), .SIZE_BITS(SIZE_BITS), .IS_BID(1'b1)) u_bid (
      .clk_i         (clk_i),
      .ctrl_i        (bid_ctrl),
      .occ_i         (CW'(i) < bid_cnt_q),
      .price_i       (price_q),
      .size_i        (size_q),
      .left_before_i ((i == 0) ? 1'b1 : bid_before[(i == 0) ? 0 : i-1]),
      .left_price_i  (bid_p[(i == 0) ? 0 : i-1]),
      .left_size_i   (bid_s[(i == 0) ? 0 : i-1]),
      .right_price_i (bid_p[(i == LEVELS-1) ? i : i+1]),
      .right_size_i  (bid_s[(i == LEVELS-1) ? i : i+1]),
      .price_o       (bid_p[i]),
      .size_o        (bid_s[i]),
      .before_o      (bid_before[i]),
      .eq_o          (bid_eq[i])
    );
    plob_cell #(.PRICE_BITS(PRICE_BITS), .SIZE_BITS(SIZE_BITS), .IS_BID(1'b0)) u_ask (
      .clk_i         (clk_i),
      .ctrl_i        (ask_ctrl),
      .occ_i         (CW'(i) < ask_cnt_q),
      .price_i       (price_q),
      .size_i        (size_q),
      .left_before_i ((i == 0) ? 1'b1 : ask_before[(i == 0) ? 0 : i-1]),
      .left_price_i  (ask_p[(i == 0) ? 0 : i-1]),
      .left_size_i   (ask_s[(i == 0) ? 0 : i-1]),
      .right_price_i (ask_p[(i == LEVELS-1) ? i : i+1]),
      .right_size_i  (ask_s[(i == LEVELS-1) ? i : i+1]),
      .price_o       (ask_p[i]),
      .size_o        (ask_s[i]),
      .before_o      (ask_before[i]),
      .eq_o          (ask_eq[i])
    );
  end

  // side of the current transaction
  logic side_found, side_full, remove, delta_ok;
  logic [CW-1:0] side_cnt;
  cell_op_e apply_op;
  status_e apply_stat;
  logic [SIZE_BITS-1:0] q_size;

  assign side_cnt   = is_bid_q ? bid_cnt_q : ask_cnt_q;
  assign side_found = is_bid_q ? (|bid_eq) : (|ask_eq);
  assign side_full  = (side_cnt == CW'(LEVELS));
  assign remove     = (act_q == ACT_DELETE) || (size_q == '0);
  assign delta_ok   = (req_q == REQ_DELTA) && (instr_q == inst_q) && (act_q != ACT_NONE);

  always_comb begin
    apply_op = OP_HOLD;
    if (delta_ok) begin
      if (remove) apply_op = side_found ? OP_REM : OP_HOLD;
      else if (side_found) apply_op = OP_UPD;
      else if (!side_full) apply_op = OP_INS;
    end
  end

  always_comb begin
    apply_stat = ST_OK;
    if (req_q == REQ_DELTA) begin
      if (instr_q != inst_q) apply_stat = ST_FOREIGN;
      else if (act_q != ACT_NONE && !remove && !side_found && side_full) apply_stat = ST_FULL;
    end
  end

  always_comb begin
    q_size = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (is_bid_q ? bid_eq[i] : ask_eq[i]) q_size |= (is_bid_q ? bid_s[i] : ask_s[i]);
    end
  end

  always_comb begin
    bid_ctrl.op = OP_HOLD;
    ask_ctrl.op = OP_HOLD;
    if (state_q == S_CMP) begin
      bid_ctrl.op = OP_CMP;
      ask_ctrl.op = OP_CMP;
    end else if (state_q == S_APPLY) begin
      if (is_bid_q) bid_ctrl.op = apply_op;
      else ask_ctrl.op = apply_op;
    end
  end

  // snapshot length: min of depth, levels held and result limit
  logic [CW-1:0] snap_n;
  always_comb begin
    logic [6:0] n;
    n = 7'(depth_q);
    if (7'(side_cnt) < n) n = 7'(side_cnt);
    if (n > 7'(MAX_RESULTS)) n = 7'(MAX_RESULTS);
    snap_n = CW'(n);
  end

  logic in_acc, out_load, emit_last;
  assign in_acc    = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_load  = !out_valid_q || !out_stall_i;
  assign emit_last = (nres_q == '0) || ((CW'(k_q) + CW'(1)) >= nres_q);

  logic [PRICE_BITS-1:0] snap_p;
  logic [SIZE_BITS-1:0]  snap_s;
  assign snap_p = is_bid_q ? bid_p[k_q] : ask_p[k_q];
  assign snap_s = is_bid_q ? bid_s[k_q] : ask_s[k_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      inst_q      <= '0;
      bid_cnt_q   <= '0;
      ask_cnt_q   <= '0;
      nres_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      stat_q      <= ST_OK;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_INSTRUMENT) inst_q <= pwdata[15:0];
      if (state_q == S_EMIT && out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) state_q <= S_CMP;
        end
        S_CMP: begin
          state_q <= S_APPLY;
        end
        S_APPLY: begin
          stat_q <= apply_stat;
          k_q    <= '0;
          nres_q <= (req_q == REQ_SNAP) ? snap_n : CW'(1);
          if (req_q == REQ_CLEAR) begin
            bid_cnt_q <= '0;
            ask_cnt_q <= '0;
          end else if (req_q == REQ_DELTA) begin
            if (apply_op == OP_INS) begin
              if (is_bid_q) bid_cnt_q <= bid_cnt_q + CW'(1);
              else ask_cnt_q <= ask_cnt_q + CW'(1);
            end else if (apply_op == OP_REM) begin
              if (is_bid_q) bid_cnt_q <= bid_cnt_q - CW'(1);
              else ask_cnt_q <= ask_cnt_q - CW'(1);
            end
          end
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            k_q <= k_q + KW'(1);
            if (emit_last) state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // book summary from the head cells
  logic bp, ap;
  logic [PRICE_BITS-1:0] bb, ba;
  logic [63:0] diff, sum;
  assign bp   = (bid_cnt_q != '0);
  assign ap   = (ask_cnt_q != '0);
  assign bb   = bp ? bid_p[0] : '0;
  assign ba   = ap ? ask_p[0] : '1;
  assign diff = 64'(ba) - 64'(bb);
  assign sum  = 64'(ba) + 64'(bb);

  // captured request and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q    <= req_e'(req_type_i);
      instr_q  <= instrument_i;
      is_bid_q <= is_bid_i;
      act_q    <= action_e'(action_i);
      price_q  <= in_price;
      size_q   <= in_size;
      depth_q  <= depth_i;
    end
    if (state_q == S_EMIT && out_load) begin
      o_status_q <= stat_q;
      o_last_q   <= emit_last;
      // summary is taken with the result so a stalled transaction holds it
      o_bb_q     <= 32'(64'(bb));
      o_ba_q     <= 32'(64'(ba));
      o_bp_q     <= bp;
      o_ap_q     <= ap;
      o_sp_q     <= (bp && ap) ? diff[32:0] : '0;
      o_mid_q    <= (bp && ap) ? sum[32:0] : '0;
      o_empty_q  <= !bp && !ap;
      if (req_q == REQ_QUERY) begin
        o_lp_q <= 32'(64'(price_q));
        o_ls_q <= 32'(64'(q_size));
        o_lv_q <= side_found;
      end else if (req_q == REQ_SNAP && nres_q != '0) begin
        o_lp_q <= 32'(64'(snap_p));
        o_ls_q <= 32'(64'(snap_s));
        o_lv_q <= 1'b1;
      end else begin
        o_lp_q <= '0;
        o_ls_q <= '0;
        o_lv_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = o_status_q;
  assign best_bid_o    = o_bb_q;
  assign best_ask_o    = o_ba_q;
  assign bid_present_o = o_bp_q;
  assign ask_present_o = o_ap_q;
  assign spread_o      = o_sp_q;
  assign mid_twice_o   = o_mid_q;
  assign level_price_o = o_lp_q;
  assign level_size_o  = o_ls_q;
  assign level_valid_o = o_lv_q;
  assign last_o        = o_last_q;
  assign book_empty_o  = o_empty_q;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_INSTRUMENT) ? {16'd0, inst_q} : '0;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bid_cnt_q <= CW'(LEVELS)) && (ask_cnt_q <= CW'(LEVELS)))
    else $error("level count beyond capacity");
  a_unique_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPLY) |-> ($onehot0(bid_eq) && $onehot0(ask_eq)))
    else $error("price held in more than one cell");
  a_apply_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPLY) |=> (state_q == S_EMIT))
    else $error("sequencer skipped result stage");
`endif

endmodule
